### rtl/core/dlhr_pkg.sv
// Shared types and constants for the dual light hysteresis relay controller.
// No dependencies; imported by the core and its checker.
`timescale 1ns / 1ps

package dlhr_pkg;

  localparam int unsigned LUX_W    = 21;
  localparam int unsigned LVL_W    = 16;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned RELAYS   = 4;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 32;

  // 1000 lux in Q4
  localparam logic [LUX_W-1:0] LUX_MAX_Q4 = 21'd16000;

  // reset values of the registers
  localparam logic [LVL_W-1:0]  SETPOINT_RST = 16'd4800;
  localparam logic [LVL_W-1:0]  HYST_RST     = 16'd800;
  localparam logic [TIME_W-1:0] DWELL_RST    = 32'd10000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SETPOINT = 2'd0,
    REG_HYST     = 2'd1,
    REG_DWELL    = 2'd2,
    REG_AUTO     = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    STAT_ACCEPT  = 2'd0,
    STAT_REJECT  = 2'd1,
    STAT_MANUAL  = 2'd2,
    STAT_IGNORED = 2'd3
  } status_t;

  typedef enum logic {
    REQ_SAMPLE = 1'b0,
    REQ_MANUAL = 1'b1
  } req_t;

endpackage

### rtl/core/dual_light_hysteresis_relay_ctrl_unit.sv
// Top level of the dual light hysteresis relay controller.
// Depends on dlhr_pkg.
`timescale 1ns / 1ps

// Two-stage block: an input register and a result register with one level of
// compare/timer logic between them. One item is accepted per clock unless
// out_ready stalls the result register; an item's result loads into the result
// register as it leaves the input register, and the relay and per-channel pending
// state is updated at the same edge, so the next item always sees it. Throughput
// is one item per cycle, limited only by out_ready. Configuration writes are always
// accepted (cfg_ready is high) and must only be issued while no item is in flight.
module dual_light_hysteresis_relay_ctrl_unit #(
  parameter int unsigned NUM_CHANNELS = 2
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // configuration
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [dlhr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dlhr_pkg::CFG_DATA_W-1:0] cfg_data,
  // input items
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_req_type,
  input  logic                            in_channel,
  input  logic [31:0]                     in_now_ms,
  input  logic signed [20:0]              in_lux_q4,
  input  logic [1:0]                      in_relay_index,
  input  logic                            in_relay_value,
  // results
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [3:0]                      out_relay_bits,
  output logic [1:0]                      out_status,
  output logic                            out_relays_changed
);

  import dlhr_pkg::*;

  // configuration registers
  logic [LVL_W-1:0]  setpoint_r;
  logic [LVL_W-1:0]  hyst_r;
  logic [TIME_W-1:0] dwell_r;
  logic              auto_r;

  // input stage
  logic              s1_vld_r;
  logic              s1_req_r;
  logic              s1_chan_r;
  logic [TIME_W-1:0] s1_now_r;
  logic [LUX_W-1:0]  s1_lux_r;
  logic [1:0]        s1_ridx_r;
  logic              s1_rval_r;

  // result stage
  logic              out_vld_r;
  logic [RELAYS-1:0] out_relay_r;
  status_t           out_stat_r;
  logic              out_chg_r;

  // block state
  logic [RELAYS-1:0] relay_r;
  logic [RELAYS-1:0] relay_nxt;
  logic              low_pend_r  [NUM_CHANNELS];
  logic              high_pend_r [NUM_CHANNELS];
  logic [TIME_W-1:0] low_start_r [NUM_CHANNELS];
  logic [TIME_W-1:0] high_start_r[NUM_CHANNELS];

  logic              in_xfer;
  logic              advance;

  // selected channel view and its update
  logic              sel_lp;
  logic              sel_hp;
  logic [TIME_W-1:0] sel_ls;
  logic [TIME_W-1:0] sel_hs;
  logic              lp_nxt;
  logic              hp_nxt;
  logic              ls_load;
  logic              hs_load;
  logic              chan_upd;
  status_t           stat_nxt;

  logic              chan_ok;
  logic              lux_ok;
  logic              low_cond;
  logic              high_cond;
  logic [LVL_W-1:0]  on_level;
  logic [LVL_W:0]    off_level;
  logic [TIME_W-1:0] low_elapsed;
  logic [TIME_W-1:0] high_elapsed;
  logic [RELAYS-1:0] pair;
  logic [RELAYS-1:0] ridx_mask;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      setpoint_r <= SETPOINT_RST;
      hyst_r     <= HYST_RST;
      dwell_r    <= DWELL_RST;
      auto_r     <= 1'b1;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_SETPOINT: setpoint_r <= cfg_data[LVL_W-1:0];
        REG_HYST:     hyst_r     <= cfg_data[LVL_W-1:0];
        REG_DWELL:    dwell_r    <= cfg_data[TIME_W-1:0];
        REG_AUTO:     auto_r     <= cfg_data[0];
        default:      ;
      endcase
    end
  end

  // handshake: the result register parts the two sides
  assign advance  = s1_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !s1_vld_r || advance;
  assign in_xfer  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_xfer) begin
      s1_vld_r <= 1'b1;
    end else if (advance) begin
      s1_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_req_r  <= in_req_type;
      s1_chan_r <= in_channel;
      s1_now_r  <= in_now_ms;
      s1_lux_r  <= in_lux_q4;
      s1_ridx_r <= in_relay_index;
      s1_rval_r <= in_relay_value;
    end
  end

  // pick the addressed channel's pending state
  always_comb begin
    sel_lp = 1'b0;
    sel_hp = 1'b0;
    sel_ls = '0;
    sel_hs = '0;
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      if (32'(s1_chan_r) == c) begin
        sel_lp = low_pend_r[c];
        sel_hp = high_pend_r[c];
        sel_ls = low_start_r[c];
        sel_hs = high_start_r[c];
      end
    end
  end

  assign chan_ok  = 32'(s1_chan_r) < NUM_CHANNELS;
  assign lux_ok   = !s1_lux_r[LUX_W-1] && (s1_lux_r <= LUX_MAX_Q4);
  // low threshold never reached when hysteresis >= setpoint (level <= 0)
  assign on_level  = setpoint_r - hyst_r;
  assign off_level = {1'b0, setpoint_r} + {1'b0, hyst_r};
  assign low_cond  = (setpoint_r > hyst_r) && (s1_lux_r[LVL_W-1:0] < on_level);
  assign high_cond = {1'b0, s1_lux_r[LVL_W-1:0]} > off_level;
  assign low_elapsed  = s1_now_r - sel_ls;
  assign high_elapsed = s1_now_r - sel_hs;
  assign pair      = 4'b0101 << s1_chan_r;
  assign ridx_mask = 4'b0001 << s1_ridx_r;

  always_comb begin
    relay_nxt = relay_r;
    stat_nxt  = STAT_ACCEPT;
    lp_nxt    = sel_lp;
    hp_nxt    = sel_hp;
    ls_load   = 1'b0;
    hs_load   = 1'b0;
    chan_upd  = 1'b0;
    if (s1_req_r == REQ_SAMPLE) begin
      if (!chan_ok || !lux_ok) begin
        stat_nxt = STAT_REJECT;
      end else if (auto_r) begin
        chan_upd = 1'b1;
        priority if (low_cond) begin
          hp_nxt = 1'b0;
          if (!sel_lp) begin
            lp_nxt  = 1'b1;
            ls_load = 1'b1;
          end else if (low_elapsed >= dwell_r) begin
            relay_nxt = relay_r | pair;
          end
        end else if (high_cond) begin
          lp_nxt = 1'b0;
          if (!sel_hp) begin
            hp_nxt  = 1'b1;
            hs_load = 1'b1;
          end else if (high_elapsed >= dwell_r) begin
            relay_nxt = relay_r & ~pair;
          end
        end else begin
          lp_nxt = 1'b0;
          hp_nxt = 1'b0;
        end
      end
    end else begin
      if (auto_r) begin
        stat_nxt = STAT_IGNORED;
      end else begin
        stat_nxt  = STAT_MANUAL;
        relay_nxt = s1_rval_r ? (relay_r | ridx_mask) : (relay_r & ~ridx_mask);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      relay_r <= '0;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        low_pend_r[c]  <= 1'b0;
        high_pend_r[c] <= 1'b0;
      end
    end else if (advance) begin
      relay_r <= relay_nxt;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        if (chan_upd && (32'(s1_chan_r) == c)) begin
          low_pend_r[c]  <= lp_nxt;
          high_pend_r[c] <= hp_nxt;
        end
      end
    end
  end

  // start times are only read while their pending flag is set
  always_ff @(posedge clk) begin
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      if (advance && (32'(s1_chan_r) == c)) begin
        if (ls_load) low_start_r[c]  <= s1_now_r;
        if (hs_load) high_start_r[c] <= s1_now_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_relay_r <= relay_nxt;
      out_stat_r  <= stat_nxt;
      out_chg_r   <= relay_nxt != relay_r;
    end
  end

  assign out_valid          = out_vld_r;
  assign out_relay_bits     = out_relay_r;
  assign out_status         = out_stat_r;
  assign out_relays_changed = out_chg_r;

endmodule

### rtl/core/dlhr_checker.sv
// Port-level checker for the dual light hysteresis relay controller.
// Depends on dlhr_pkg; bound to dual_light_hysteresis_relay_ctrl_unit below.
`timescale 1ns / 1ps

module dlhr_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [3:0] out_relay_bits,
  input logic [1:0] out_status,
  input logic       out_relays_changed
);

  import dlhr_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_relay_bits)
      && $stable(out_status) && $stable(out_relays_changed))
    else $error("result changed while stalled");

  // no result comes out of reset
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // rejected samples and ignored writes never switch a relay
  a_no_switch: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == STAT_REJECT || out_status == STAT_IGNORED)
      |-> !out_relays_changed)
    else $error("relay switched on rejected or ignored item");

  // an idle block with a drained output takes a new item
  a_accept: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && !$past(in_valid) && !$past(out_valid) |-> in_ready)
    else $error("input not ready while empty");

  // a result with no relay change, followed by a rejected or ignored one, keeps the relay bits
  a_chg_bits: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_relays_changed ##1 out_valid
      && (out_status == STAT_REJECT || out_status == STAT_IGNORED)
      |-> $stable(out_relay_bits))
    else $error("relay bits moved without a change");

endmodule

bind dual_light_hysteresis_relay_ctrl_unit dlhr_checker u_dlhr_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_ready           (in_ready),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_relay_bits     (out_relay_bits),
  .out_status         (out_status),
  .out_relays_changed (out_relays_changed)
);
